// File: hw/rtl/flow_area_wetted_perimeter_macros.svh
// Assertion macros shared by the checker.
`ifndef FLOW_AREA_WETTED_PERIMETER_MACROS_SVH
`define FLOW_AREA_WETTED_PERIMETER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define FAWP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("property failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define FAWP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("property failed");

`endif

// File: hw/rtl/fawp_pkg.sv
package fawp_pkg;

  // Field widths.
  localparam int COORD_W  = 24;
  localparam int AREA_W   = 2 * COORD_W;
  localparam int PERIM_W  = COORD_W + 16;
  localparam int RADIUS_W = COORD_W;

  // Shared shift-subtract unit sizing.
  localparam int OPD_W      = 2 * COORD_W + 2;
  localparam int REM_W      = PERIM_W + 2;
  localparam int ROOT_W     = COORD_W + 1;
  localparam int DIV_STEPS  = COORD_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int CNT_W      = $clog2(ROOT_W + 1);

  // Stream payload widths.
  localparam int IN_W  = 2 * COORD_W;
  localparam int OUT_W = AREA_W + PERIM_W + RADIUS_W;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } fawp_unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fawp_unit_sts_t;

endpackage

// File: hw/rtl/fawp_shift_sub.sv
module fawp_shift_sub
  import fawp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fawp_unit_req_t      req_i,
  input  logic [OPD_W-1:0]    opd_i,
  input  logic [PERIM_W-1:0]  den_i,
  input  logic [PERIM_W-1:0]  rem0_i,
  output fawp_unit_sts_t      sts_o,
  output logic [ROOT_W-1:0]   res_o
);

  logic [REM_W-1:0]   rem_q;
  logic [OPD_W-1:0]   opd_q;
  logic [ROOT_W-1:0]  acc_q;
  logic [PERIM_W-1:0] den_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               sqrt_q;
  logic               busy_q;
  logic               done_q;

  logic [REM_W-1:0]   shifted;
  logic [REM_W-1:0]   trial;
  logic               ge;
  logic               last_step;

  // One restoring step: one quotient bit, or one root bit per bit pair.
  always_comb begin
    if (sqrt_q) begin
      shifted = {rem_q[REM_W-3:0], opd_q[OPD_W-1 -: 2]};
      trial   = {{(REM_W-ROOT_W-2){1'b0}}, acc_q, 2'b01};
    end else begin
      shifted = {rem_q[REM_W-2:0], opd_q[OPD_W-1]};
      trial   = {{(REM_W-PERIM_W){1'b0}}, den_q};
    end
    ge = shifted >= trial;
    last_step = sqrt_q ? (cnt_q == CNT_W'(SQRT_STEPS - 1))
                       : (cnt_q == CNT_W'(DIV_STEPS - 1));
  end

  // Control: step counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        sqrt_q <= req_i.is_sqrt;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last_step) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, operand shifter and result bits.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.is_sqrt ? '0 : {{(REM_W-PERIM_W){1'b0}}, rem0_i};
      opd_q <= opd_i;
      acc_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? (shifted - trial) : shifted;
      opd_q <= sqrt_q ? {opd_q[OPD_W-3:0], 2'b00} : {opd_q[OPD_W-2:0], 1'b0};
      acc_q <= {acc_q[ROOT_W-2:0], ge};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign res_o      = acc_q;

endmodule

// File: hw/rtl/flow_area_wetted_perimeter.sv
// Flow area and wetted perimeter of a channel cross-section.
// Input stream: one vertex per transfer, left to right. tdata carries x_pos and
// depth_pos (unsigned Q16.8), tuser marks the first vertex, tlast the last one.
// The user must write the water surface depth through cfg_we_i/cfg_wdata_i only
// while idle; the block itself does not enforce this. Output stream: one transfer
// per section, sent after the last vertex, with flow area, wetted perimeter and
// hydraulic radius; tuser says the radius is valid. A wet segment needs a square
// root for its length, and a crossing of the surface adds a divide; the crossing
// needs a 24-step divide and the length a 25-step square root, both on the one
// shared shift-subtract unit. The last vertex adds the radius divide, when one is
// needed, and the output load.
// The input is not ready while a vertex is being worked on.
// A finished result waits in the output register; new vertices are accepted
// meanwhile, and only a following last vertex waits until the receiver takes it.
// Reset clears the sums, the stored vertex, the surface level and the output valid flag.
module flow_area_wetted_perimeter
  import fawp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COORD_W-1:0] cfg_wdata_i,   // water_surface_level
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [IN_W-1:0]    s_axis_tdata,  // x_pos, depth_pos
  input  logic               s_axis_tuser,  // first_point
  input  logic               s_axis_tlast,  // last_point
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [OUT_W-1:0]   m_axis_tdata,  // flow_area, wetted_perimeter, hydraulic_radius
  output logic               m_axis_tuser   // radius_valid
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLIP  = 4'd1;
  localparam logic [3:0] ST_DIV   = 4'd2;
  localparam logic [3:0] ST_DIVW  = 4'd3;
  localparam logic [3:0] ST_GEOM  = 4'd4;
  localparam logic [3:0] ST_AREA  = 4'd5;
  localparam logic [3:0] ST_SQ1   = 4'd6;
  localparam logic [3:0] ST_SQ2   = 4'd7;
  localparam logic [3:0] ST_SQRTW = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;
  localparam logic [3:0] ST_FDIVW = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  localparam int MUL_W = COORD_W + 1;
  localparam int PROD_W = 2 * MUL_W;

  logic [3:0]          state_q, state_d;
  logic [COORD_W-1:0]  level_q;
  logic [COORD_W-1:0]  prev_x_q, prev_y_q;
  logic                have_prev_q;
  logic [AREA_W-1:0]   area_q;
  logic [PERIM_W-1:0]  perim_q;
  logic [COORD_W-1:0]  sx1_q, sy1_q, sx2_q, sy2_q;
  logic                last_q;
  logic                clip_up_q;
  logic [COORD_W-1:0]  den_q;
  logic [PROD_W-1:0]   prod_q;
  logic [AREA_W-1:0]   s1_q;
  logic [RADIUS_W-1:0] rad_q;
  logic                rvalid_q;
  logic                out_valid_q;
  logic [OUT_W-1:0]    out_data_q;
  logic                out_user_q;

  logic               s_xfer;
  logic               seg;
  logic               up, down, dx_neg;
  logic [COORD_W-1:0] mag, num, den, off, new_x;
  logic [MUL_W-1:0]   b1, b2, h, bsum, db;
  logic               skip;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [AREA_W:0]    area_sum;
  logic [PERIM_W:0]   perim_sum;
  logic [OPD_W-1:0]   radicand;
  logic               fin_zero, fin_sat;
  logic               out_load;

  fawp_unit_req_t     u_req;
  fawp_unit_sts_t     u_sts;
  logic [OPD_W-1:0]   u_opd;
  logic [PERIM_W-1:0] u_den, u_rem0;
  logic [ROOT_W-1:0]  u_res;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign seg = have_prev_q && !s_axis_tuser;

  // Segment geometry against the surface level.
  always_comb begin
    up     = (sy2_q > level_q) && (sy1_q < level_q);
    down   = (sy2_q < level_q) && (sy1_q > level_q);
    dx_neg = sx2_q < sx1_q;
    mag    = dx_neg ? (sx1_q - sx2_q) : (sx2_q - sx1_q);
    num    = up ? (level_q - sy1_q) : (sy1_q - level_q);
    den    = up ? (sy2_q - sy1_q) : (sy1_q - sy2_q);
    off    = u_res[COORD_W-1:0];
    new_x  = dx_neg ? (sx1_q - off) : (sx1_q + off);
    b1     = {1'b0, sy1_q} - {1'b0, level_q};
    b2     = {1'b0, sy2_q} - {1'b0, level_q};
    h      = {1'b0, sx2_q} - {1'b0, sx1_q};
    skip   = b1[MUL_W-1] || b2[MUL_W-1] || h[MUL_W-1] || (h == '0)
             || ((b1 == '0) && (b2 == '0));
    bsum   = b1 + b2;
    db     = (b2 >= b1) ? (b2 - b1) : (b1 - b2);
  end

  // Shared multiplier operand selection; the product is registered.
  always_comb begin
    case (state_q)
      ST_CLIP: begin
        mul_a = {1'b0, mag};
        mul_b = {1'b0, num};
      end
      ST_GEOM: begin
        mul_a = bsum;
        mul_b = h;
      end
      ST_AREA: begin
        mul_a = db;
        mul_b = db;
      end
      ST_SQ1: begin
        mul_a = h;
        mul_b = h;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Saturating sums and the final radius checks.
  always_comb begin
    area_sum  = {1'b0, area_q} + {1'b0, prod_q[AREA_W:1]};
    perim_sum = {1'b0, perim_q} + {{(PERIM_W+1-ROOT_W){1'b0}}, u_res};
    radicand  = prod_q + {{(PROD_W-AREA_W){1'b0}}, s1_q};
    fin_zero  = (perim_q == '0);
    fin_sat   = {{(PERIM_W-COORD_W){1'b0}}, area_q[AREA_W-1:COORD_W]} >= perim_q;
    out_load  = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
  end

  // Requests to the shift-subtract unit.
  always_comb begin
    u_req.start   = 1'b0;
    u_req.is_sqrt = 1'b0;
    u_opd  = '0;
    u_den  = '0;
    u_rem0 = '0;
    case (state_q)
      ST_DIV: begin
        u_req.start = 1'b1;
        u_opd  = {prod_q[COORD_W-1:0], {(OPD_W-COORD_W){1'b0}}};
        u_den  = {{(PERIM_W-COORD_W){1'b0}}, den_q};
        u_rem0 = {{(PERIM_W-COORD_W){1'b0}}, prod_q[AREA_W-1:COORD_W]};
      end
      ST_SQ2: begin
        u_req.start   = 1'b1;
        u_req.is_sqrt = 1'b1;
        u_opd = radicand;
      end
      ST_FIN: begin
        u_req.start = !fin_zero && !fin_sat;
        u_opd  = {area_q[COORD_W-1:0], {(OPD_W-COORD_W){1'b0}}};
        u_den  = perim_q;
        u_rem0 = {{(PERIM_W-COORD_W){1'b0}}, area_q[AREA_W-1:COORD_W]};
      end
      default: begin
        u_req.start = 1'b0;
      end
    endcase
  end

  fawp_shift_sub u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (u_req),
    .opd_i  (u_opd),
    .den_i  (u_den),
    .rem0_i (u_rem0),
    .sts_o  (u_sts),
    .res_o  (u_res)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          if (seg) state_d = ST_CLIP;
          else if (s_axis_tlast) state_d = ST_FIN;
        end
      end
      ST_CLIP: state_d = (up || down) ? ST_DIV : ST_GEOM;
      ST_DIV: state_d = ST_DIVW;
      ST_DIVW: begin
        if (u_sts.done) state_d = ST_GEOM;
      end
      ST_GEOM: begin
        if (!skip) state_d = ST_AREA;
        else state_d = last_q ? ST_FIN : ST_IDLE;
      end
      ST_AREA: state_d = ST_SQ1;
      ST_SQ1: state_d = ST_SQ2;
      ST_SQ2: state_d = ST_SQRTW;
      ST_SQRTW: begin
        if (u_sts.done) state_d = last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: state_d = u_req.start ? ST_FDIVW : ST_OUT;
      ST_FDIVW: begin
        if (u_sts.done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, sums and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      level_q     <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      area_q      <= '0;
      perim_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) level_q <= cfg_wdata_i;
      if (s_xfer) begin
        prev_x_q    <= s_axis_tdata[COORD_W-1:0];
        prev_y_q    <= s_axis_tdata[IN_W-1:COORD_W];
        have_prev_q <= 1'b1;
        if (s_axis_tuser) begin
          area_q  <= '0;
          perim_q <= '0;
        end
      end
      if (state_q == ST_AREA) begin
        area_q <= area_sum[AREA_W] ? '1 : area_sum[AREA_W-1:0];
      end
      if ((state_q == ST_SQRTW) && u_sts.done) begin
        perim_q <= perim_sum[PERIM_W] ? '1 : perim_sum[PERIM_W-1:0];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        area_q      <= '0;
        perim_q     <= '0;
        have_prev_q <= 1'b0;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the current segment and result.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (s_xfer) begin
      sx1_q  <= prev_x_q;
      sy1_q  <= prev_y_q;
      sx2_q  <= s_axis_tdata[COORD_W-1:0];
      sy2_q  <= s_axis_tdata[IN_W-1:COORD_W];
      last_q <= s_axis_tlast;
    end
    if (state_q == ST_CLIP) begin
      clip_up_q <= up;
      den_q     <= den;
    end
    if ((state_q == ST_DIVW) && u_sts.done) begin
      if (clip_up_q) begin
        sx1_q <= new_x;
        sy1_q <= level_q;
      end else begin
        sx2_q <= new_x;
        sy2_q <= level_q;
      end
    end
    if (state_q == ST_SQ1) s1_q <= prod_q[AREA_W-1:0];
    if (state_q == ST_FIN) begin
      rad_q    <= fin_zero ? '0 : '1;
      rvalid_q <= !fin_zero;
    end
    if ((state_q == ST_FDIVW) && u_sts.done) rad_q <= u_res[RADIUS_W-1:0];
    if (out_load) begin
      out_data_q <= {rad_q, perim_q, area_q};
      out_user_q <= rvalid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// File: hw/rtl/fawp_checker.sv
`include "flow_area_wetted_perimeter_macros.svh"

module fawp_checker
  import fawp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [COORD_W-1:0] cfg_wdata_i,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic [IN_W-1:0]    s_axis_tdata,
  input logic               s_axis_tuser,
  input logic               s_axis_tlast,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [OUT_W-1:0]   m_axis_tdata,
  input logic               m_axis_tuser
);

  logic perim_nz;
  logic rad_zero;
  logic last_xfer;

  assign perim_nz  = m_axis_tdata[AREA_W+PERIM_W-1:AREA_W] != '0;
  assign rad_zero  = m_axis_tdata[OUT_W-1:AREA_W+PERIM_W] == '0;
  assign last_xfer = s_axis_tvalid && s_axis_tready && s_axis_tlast;

  // A stalled result holds.
  `FAWP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // Radius is valid exactly when the perimeter is nonzero.
  `FAWP_ASSERT_IMP(a_valid_perim, m_axis_tvalid, m_axis_tuser == perim_nz)
  // An invalid radius reads zero.
  `FAWP_ASSERT_IMP(a_rad_zero, m_axis_tvalid && !m_axis_tuser, rad_zero)
  // The last vertex always keeps the block busy for the result.
  `FAWP_ASSERT_NXT(a_last_busy, last_xfer, !s_axis_tready)

endmodule

bind flow_area_wetted_perimeter fawp_checker u_fawp_checker (.*);
